>>> hdl/sacc_pkg.sv
// ----------------------------------------------------------------------------
// sacc_pkg
// Shared types and constants of the set-associative cache controller.
// ----------------------------------------------------------------------------
package sacc_pkg;

    localparam int NUM_SETS    = 64;
    localparam int WAYS        = 4;
    localparam int BLOCK_BYTES = 64;
    localparam int ADDR_BITS   = 32;

    localparam int OFF_BITS  = $clog2(BLOCK_BYTES);
    localparam int SET_BITS  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WAY_BITS  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int TAG_BITS  = ADDR_BITS - OFF_BITS - $clog2(NUM_SETS);
    localparam int PADDR_BITS = 4;

    localparam logic [1:0] CMD_DONE    = 2'd0;
    localparam logic [1:0] CMD_WBACK   = 2'd1;
    localparam logic [1:0] CMD_FETCH   = 2'd2;
    localparam logic [1:0] CMD_FORWARD = 2'd3;

    localparam logic [1:0] POL_LRU  = 2'd0;
    localparam logic [1:0] POL_MRU  = 2'd1;
    localparam logic [1:0] POL_RAND = 2'd2;

    localparam logic [PADDR_BITS-1:0] REG_POLICY = 4'h0;
    localparam logic [PADDR_BITS-1:0] REG_MULT   = 4'h4;
    localparam logic [PADDR_BITS-1:0] REG_INC    = 4'h8;
    localparam logic [PADDR_BITS-1:0] REG_MOD    = 4'hC;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_LOOK,
        ST_MUL,
        ST_MOD,
        ST_DECIDE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic                valid;
        logic                dirty;
        logic [TAG_BITS-1:0] tag;
        logic [31:0]         stamp;
    } line_t;

endpackage

>>> hdl/set_assoc_cache_controller.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_controller
// Tag, state and replacement control of a set-associative cache.
// ----------------------------------------------------------------------------
// Use: an access (op, address, store_through) is a transfer on the input
// channel (valid high, stall low). Each access produces one to three result
// transfers (command, line_address, way, hit, last); the last one has last
// set. The output holds its payload while stall is high.
// The line state of a set lives in one synchronous memory word read per
// access; the per-set stamp counter and generator state live in a second
// memory. Both are read at the input transfer, latched, looked up and
// written back in the decide state, after which the results are offered one
// per cycle while stall is low. The random policy adds a generator step on
// a read miss to a full set: a 32 by 32 multiply done as a low and a high
// partial product, then a bit-serial modulo of the 64-bit product by the
// configured modulus.
// One access is in work at a time, so input is stalled until the last
// result has been taken.
// Reset clears the line store with a pass over all sets during which no
// access is taken; configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module set_assoc_cache_controller
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sacc_pkg::PADDR_BITS-1:0]     paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                op,
    input  logic [31:0]                         address,
    input  logic                                store_through,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [1:0]                          command,
    output logic [31:0]                         line_address,
    output logic [1:0]                          way,
    output logic                                hit,
    output logic                                last
);

    localparam int W   = sacc_pkg::WAYS;
    localparam int WB  = sacc_pkg::WAY_BITS;
    localparam int SB  = sacc_pkg::SET_BITS;
    localparam int TB  = sacc_pkg::TAG_BITS;
    localparam int OB  = sacc_pkg::OFF_BITS;
    localparam int LOGSETS = $clog2(sacc_pkg::NUM_SETS);
    localparam int CNTB = $clog2(64 + 1);

    // ---------------- configuration ----------------
    logic [1:0]  policy_reg;
    logic [31:0] mult_reg, inc_reg, mod_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= sacc_pkg::POL_LRU;
            mult_reg   <= 32'd1103515245;
            inc_reg    <= 32'd12345;
            mod_reg    <= 32'd2147483647;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr)
                sacc_pkg::REG_POLICY: policy_reg <= (pwdata[1:0] == 2'd3) ? sacc_pkg::POL_LRU
                                                                         : pwdata[1:0];
                sacc_pkg::REG_MULT:   mult_reg <= pwdata;
                sacc_pkg::REG_INC:    inc_reg  <= pwdata;
                sacc_pkg::REG_MOD:    mod_reg  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr)
            sacc_pkg::REG_POLICY: prdata = {30'd0, policy_reg};
            sacc_pkg::REG_MULT:   prdata = mult_reg;
            sacc_pkg::REG_INC:    prdata = inc_reg;
            sacc_pkg::REG_MOD:    prdata = mod_reg;
            default:              prdata = 32'd0;
        endcase
    end

    // ---------------- memories ----------------
    sacc_pkg::line_t lines_mem [sacc_pkg::NUM_SETS][W];
    logic [63:0]     sstate_mem [sacc_pkg::NUM_SETS];   // {rng, counter}
    sacc_pkg::line_t rd_lines [W];
    logic [63:0]     rd_sstate;
    logic [SB-1:0]   rd_set;
    logic            mem_we;
    logic [SB-1:0]   mem_wa;
    sacc_pkg::line_t wr_lines [W];
    logic [63:0]     wr_sstate;

    // ---------------- control ----------------
    sacc_pkg::state_t state_reg, state_next;
    logic [SB:0]     clr_reg;
    logic            clearing;
    logic            op_reg, wt_reg;
    logic [SB-1:0]   set_reg;
    logic [TB-1:0]   tag_reg;
    sacc_pkg::line_t ln_reg [W];
    logic [31:0]     cnt_reg, rng_reg;
    logic            hit_reg;
    logic [WB-1:0]   way_reg, lru_reg, mru_reg;
    logic            all_valid_reg;
    logic [63:0]     prod_reg;
    logic [CNTB-1:0] bit_reg;
    logic [32:0]     rem_reg;
    logic [1:0]      res_reg [3];
    logic [31:0]     res_la_reg [3];
    logic [1:0]      nres_reg, idx_reg;
    logic            mul_half_reg;

    assign clearing = !clr_reg[SB];

    logic in_acc;
    assign in_stall = (state_reg != sacc_pkg::ST_IDLE) || clearing;
    assign in_acc   = in_valid && !in_stall;

    // The set is read at the input transfer so that its data are latched in
    // the following cycle.
    assign rd_set = (state_reg == sacc_pkg::ST_IDLE) ? SB'(address[31:OB]) : set_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            for (int i = 0; i < W; i++)
                lines_mem[mem_wa][i] <= wr_lines[i];
            sstate_mem[mem_wa] <= wr_sstate;
        end
        for (int i = 0; i < W; i++)
            rd_lines[i] <= lines_mem[rd_set][i];
        rd_sstate <= sstate_mem[rd_set];
    end

    // ---------------- lookup (combinational over the read set) ----------------
    logic          hit_c;
    logic [WB-1:0] hit_way_c, inv_way_c, lru_c, mru_c;
    logic          all_valid_c;
    always_comb
    begin
        hit_c = 1'b0; hit_way_c = '0; inv_way_c = '0; all_valid_c = 1'b1;
        lru_c = '0; mru_c = '0;
        for (int i = W - 1; i >= 0; i--)
        begin
            if (ln_reg[i].valid && ln_reg[i].tag == tag_reg)
            begin
                hit_c = 1'b1;
                hit_way_c = WB'(i);
            end
            if (!ln_reg[i].valid)
            begin
                all_valid_c = 1'b0;
                inv_way_c = WB'(i);
            end
        end
        for (int i = 1; i < W; i++)
        begin
            if (ln_reg[i].stamp < ln_reg[lru_c].stamp) lru_c = WB'(i);
            if (ln_reg[i].stamp > ln_reg[mru_c].stamp) mru_c = WB'(i);
        end
    end

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sacc_pkg::ST_IDLE:   if (in_acc) state_next = sacc_pkg::ST_READ;
            sacc_pkg::ST_READ:   state_next = sacc_pkg::ST_LOOK;
            sacc_pkg::ST_LOOK:
                if (!op_reg && !hit_c && all_valid_c && policy_reg == sacc_pkg::POL_RAND)
                    state_next = sacc_pkg::ST_MUL;
                else
                    state_next = sacc_pkg::ST_DECIDE;
            sacc_pkg::ST_MUL:    if (mul_half_reg) state_next = sacc_pkg::ST_MOD;
            sacc_pkg::ST_MOD:    if (bit_reg == CNTB'(1)) state_next = sacc_pkg::ST_DECIDE;
            sacc_pkg::ST_DECIDE: state_next = sacc_pkg::ST_EMIT;
            sacc_pkg::ST_EMIT:
                if (!out_stall && idx_reg == nres_reg - 2'd1) state_next = sacc_pkg::ST_IDLE;
            default:             state_next = sacc_pkg::ST_IDLE;
        endcase
    end

    // ---------------- outputs ----------------
    always_comb
    begin
        out_valid    = (state_reg == sacc_pkg::ST_EMIT);
        command      = res_reg[idx_reg];
        line_address = res_la_reg[idx_reg];
        way          = 2'(way_reg);
        hit          = hit_reg;
        last         = (idx_reg == nres_reg - 2'd1);
    end

    // ---------------- decision and write-back ----------------
    logic [31:0]    base_c, vla_c;
    logic [WB-1:0]  vic_c, tgt_way_c;
    logic [31:0]    rng_new_c;
    logic           evict_c;
    logic [32:0]    mod_eff;
    logic [15:0]    mhalf_c;
    logic [47:0]    pp_c;
    assign mod_eff = (mod_reg == 32'd0) ? 33'h1_0000_0000 : {1'b0, mod_reg};
    assign base_c  = 32'({tag_reg, set_reg, OB'(0)});

    // 16 by 32 partial product; the low half first, then the high half.
    assign mhalf_c = mul_half_reg ? mult_reg[31:16] : mult_reg[15:0];
    assign pp_c    = 48'(mhalf_c) * 48'(rng_reg);

    always_comb
    begin
        if (policy_reg == sacc_pkg::POL_RAND)      vic_c = WB'(rem_reg);
        else if (policy_reg == sacc_pkg::POL_MRU)  vic_c = mru_reg;
        else                                       vic_c = lru_reg;
        vla_c = 32'({ln_reg[vic_c].tag, set_reg, OB'(0)});
    end

    assign evict_c   = !op_reg && !hit_reg && all_valid_reg;
    assign tgt_way_c = evict_c ? vic_c : way_reg;
    assign rng_new_c = (evict_c && policy_reg == sacc_pkg::POL_RAND) ? rem_reg[31:0] : rng_reg;

    always_comb
    begin
        mem_we = 1'b0; mem_wa = set_reg;
        for (int i = 0; i < W; i++) wr_lines[i] = ln_reg[i];
        wr_sstate = {rng_reg, cnt_reg};
        if (clearing)
        begin
            mem_we = 1'b1;
            mem_wa = clr_reg[SB-1:0];
            for (int i = 0; i < W; i++) wr_lines[i] = '0;
            wr_sstate = {32'd1, 32'd0};
        end
        else if (state_reg == sacc_pkg::ST_DECIDE)
        begin
            mem_we = 1'b1;
            if (!op_reg)
            begin
                if (hit_reg)
                    wr_lines[tgt_way_c].stamp = cnt_reg + 32'd1;
                else
                begin
                    wr_lines[tgt_way_c] = '{valid: 1'b1, dirty: 1'b0, tag: tag_reg,
                                            stamp: cnt_reg + 32'd1};
                end
                wr_sstate = {rng_new_c, cnt_reg + 32'd1};
            end
            else if (hit_reg)
            begin
                wr_lines[tgt_way_c].dirty = !wt_reg;
                wr_lines[tgt_way_c].stamp = cnt_reg + 32'd1;
                wr_sstate = {rng_reg, cnt_reg + 32'd1};
            end
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sacc_pkg::ST_IDLE;
            clr_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (clearing) clr_reg <= clr_reg + (SB+1)'(1);
            if (state_reg == sacc_pkg::ST_DECIDE) idx_reg <= '0;
            else if (state_reg == sacc_pkg::ST_EMIT && !out_stall) idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            sacc_pkg::ST_IDLE:
                if (in_acc)
                begin
                    op_reg  <= op;
                    wt_reg  <= store_through;
                    set_reg <= SB'(address[31:OB]);
                    tag_reg <= TB'(address[31:OB+LOGSETS]);
                end
            sacc_pkg::ST_READ:
            begin
                for (int i = 0; i < W; i++) ln_reg[i] <= rd_lines[i];
                cnt_reg <= rd_sstate[31:0];
                rng_reg <= rd_sstate[63:32];
            end
            sacc_pkg::ST_LOOK:
            begin
                hit_reg       <= hit_c;
                all_valid_reg <= all_valid_c;
                lru_reg       <= lru_c;
                mru_reg       <= mru_c;
                way_reg       <= op_reg ? (hit_c ? hit_way_c : '0)
                                        : (hit_c ? hit_way_c : inv_way_c);
                mul_half_reg  <= 1'b0;
            end
            sacc_pkg::ST_MUL:
            begin
                if (!mul_half_reg)
                    prod_reg <= 64'(pp_c) + 64'(inc_reg);
                else
                    prod_reg <= prod_reg + {pp_c, 16'd0};
                mul_half_reg <= 1'b1;
                bit_reg <= CNTB'(64);
                rem_reg <= '0;
            end
            sacc_pkg::ST_MOD:
            begin
                logic [33:0] t;
                t = {rem_reg, prod_reg[63]};
                if (t >= {1'b0, mod_eff}) rem_reg <= 33'(t - {1'b0, mod_eff});
                else                      rem_reg <= t[32:0];
                prod_reg <= {prod_reg[62:0], 1'b0};
                bit_reg  <= bit_reg - CNTB'(1);
            end
            sacc_pkg::ST_DECIDE:
            begin
                way_reg <= tgt_way_c;
                rng_reg <= rng_new_c;
                if (!op_reg)
                begin
                    if (hit_reg)
                    begin
                        nres_reg <= 2'd1;
                        res_reg[0] <= sacc_pkg::CMD_DONE; res_la_reg[0] <= base_c;
                    end
                    else if (all_valid_reg && ln_reg[vic_c].dirty)
                    begin
                        nres_reg <= 2'd3;
                        res_reg[0] <= sacc_pkg::CMD_WBACK; res_la_reg[0] <= vla_c;
                        res_reg[1] <= sacc_pkg::CMD_FETCH; res_la_reg[1] <= base_c;
                        res_reg[2] <= sacc_pkg::CMD_DONE;  res_la_reg[2] <= base_c;
                    end
                    else
                    begin
                        nres_reg <= 2'd2;
                        res_reg[0] <= sacc_pkg::CMD_FETCH; res_la_reg[0] <= base_c;
                        res_reg[1] <= sacc_pkg::CMD_DONE;  res_la_reg[1] <= base_c;
                    end
                end
                else if (hit_reg && !wt_reg)
                begin
                    nres_reg <= 2'd1;
                    res_reg[0] <= sacc_pkg::CMD_DONE; res_la_reg[0] <= base_c;
                end
                else
                begin
                    nres_reg <= 2'd2;
                    res_reg[0] <= sacc_pkg::CMD_FORWARD; res_la_reg[0] <= base_c;
                    res_reg[1] <= sacc_pkg::CMD_DONE;    res_la_reg[1] <= base_c;
                end
            end
            sacc_pkg::ST_EMIT: ;
            default: ;
        endcase
    end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cache controller regression
// Drives read and write accesses with random gaps and output stalls, predicts
// every result from a behavioral copy of the tag store and replacement state,
// and checks each result transfer field by field in order.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 200;
    localparam int LINES = sacc_pkg::NUM_SETS * sacc_pkg::WAYS;

    typedef struct {
        logic [1:0]  command;
        logic [31:0] line_address;
        logic [1:0]  way;
        logic        hit;
        logic        last;
    } cache_result_t;

    // Behavioral copy of the controller plus the queue of pending results.
    class cache_scoreboard;
        logic [1:0]  policy;
        logic [31:0] mult;
        logic [31:0] inc;
        logic [31:0] modulus;
        logic        line_valid [LINES];
        logic        line_dirty [LINES];
        logic [31:0] line_tag [LINES];
        logic [31:0] line_stamp [LINES];
        logic [31:0] set_counter [sacc_pkg::NUM_SETS];
        logic [31:0] set_rng [sacc_pkg::NUM_SETS];
        cache_result_t pending [$];
        int errors;
        int checked;

        function new();
            policy = sacc_pkg::POL_LRU;
            mult = 32'd1103515245;
            inc = 32'd12345;
            modulus = 32'd2147483647;
            errors = 0;
            checked = 0;
            for (int i = 0; i < LINES; i++)
            begin
                line_valid[i] = 0;
                line_dirty[i] = 0;
                line_tag[i] = 0;
                line_stamp[i] = 0;
            end
            for (int s = 0; s < sacc_pkg::NUM_SETS; s++)
            begin
                set_counter[s] = 0;
                set_rng[s] = 1;
            end
        endfunction

        function void set_policy(logic [1:0] value);
            policy = (value == 2'd3) ? sacc_pkg::POL_LRU : value;
        endfunction

        function void push(logic [1:0] c, logic [31:0] la, logic [1:0] w, logic h,
                           logic l);
            cache_result_t r;
            r.command = c;
            r.line_address = la;
            r.way = w;
            r.hit = h;
            r.last = l;
            pending.push_back(r);
        endfunction

        function void touch(int set, int w);
            set_counter[set] = set_counter[set] + 1;
            line_stamp[set*sacc_pkg::WAYS + w] = set_counter[set];
        endfunction

        function int choose_victim(int set);
            logic [63:0] v;
            int best;
            best = 0;
            if (policy == sacc_pkg::POL_RAND)
            begin
                v = {32'd0, mult} * {32'd0, set_rng[set]} + {32'd0, inc};
                if (modulus != 0)
                    v = v % {32'd0, modulus};
                else
                    v = v & 64'hFFFF_FFFF;
                set_rng[set] = v[31:0];
                return int'(v % sacc_pkg::WAYS);
            end
            for (int w = 1; w < sacc_pkg::WAYS; w++)
            begin
                if (policy == sacc_pkg::POL_MRU)
                begin
                    if (line_stamp[set*sacc_pkg::WAYS + w] >
                        line_stamp[set*sacc_pkg::WAYS + best])
                        best = w;
                end
                else if (line_stamp[set*sacc_pkg::WAYS + w] <
                         line_stamp[set*sacc_pkg::WAYS + best])
                    best = w;
            end
            return best;
        endfunction

        function void note_access(logic is_write, logic [31:0] addr, logic wt);
            logic [31:0] line_no;
            logic [31:0] tag;
            logic [31:0] base;
            int set;
            int w;
            int b;
            logic found;
            logic is_hit;
            line_no = addr / sacc_pkg::BLOCK_BYTES;
            set = int'(line_no % sacc_pkg::NUM_SETS);
            tag = line_no / sacc_pkg::NUM_SETS;
            base = line_no * sacc_pkg::BLOCK_BYTES;
            b = set * sacc_pkg::WAYS;
            w = 0;
            is_hit = 0;
            for (int i = 0; i < sacc_pkg::WAYS; i++)
            begin
                if (!is_hit && line_valid[b+i] && line_tag[b+i] == tag)
                begin
                    is_hit = 1;
                    w = i;
                end
            end
            if (!is_write)
            begin
                if (!is_hit)
                begin
                    found = 0;
                    for (int i = 0; i < sacc_pkg::WAYS; i++)
                    begin
                        if (!found && !line_valid[b+i])
                        begin
                            found = 1;
                            w = i;
                        end
                    end
                    if (!found)
                    begin
                        w = choose_victim(set);
                        if (line_dirty[b+w])
                            push(sacc_pkg::CMD_WBACK,
                                 32'((line_tag[b+w] * sacc_pkg::NUM_SETS + set) *
                                     sacc_pkg::BLOCK_BYTES),
                                 2'(w), 0, 0);
                    end
                    line_tag[b+w] = tag;
                    line_valid[b+w] = 1;
                    line_dirty[b+w] = 0;
                    touch(set, w);
                    push(sacc_pkg::CMD_FETCH, base, 2'(w), 0, 0);
                end
                else
                    touch(set, w);
                push(sacc_pkg::CMD_DONE, base, 2'(w), is_hit, 1);
            end
            else if (is_hit)
            begin
                line_dirty[b+w] = !wt;
                touch(set, w);
                if (wt)
                    push(sacc_pkg::CMD_FORWARD, base, 2'(w), 1, 0);
                push(sacc_pkg::CMD_DONE, base, 2'(w), 1, 1);
            end
            else
            begin
                push(sacc_pkg::CMD_FORWARD, base, 0, 0, 0);
                push(sacc_pkg::CMD_DONE, base, 0, 0, 1);
            end
        endfunction

        function void check_result(cache_result_t got);
            cache_result_t want;
            checked++;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result cmd=%0d addr=%h", $time, got.command,
                         got.line_address);
                return;
            end
            want = pending.pop_front();
            if (want.command !== got.command)
            begin
                errors++;
                $display("%0t: command expected %0d actual %0d", $time, want.command,
                         got.command);
            end
            if (want.line_address !== got.line_address)
            begin
                errors++;
                $display("%0t: line_address expected %h actual %h", $time,
                         want.line_address, got.line_address);
            end
            if (want.way !== got.way)
            begin
                errors++;
                $display("%0t: way expected %0d actual %0d", $time, want.way, got.way);
            end
            if (want.hit !== got.hit)
            begin
                errors++;
                $display("%0t: hit expected %0d actual %0d", $time, want.hit, got.hit);
            end
            if (want.last !== got.last)
            begin
                errors++;
                $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic psel = 0;
    logic penable = 0;
    logic pwrite = 0;
    logic [sacc_pkg::PADDR_BITS-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 0;
    logic in_stall;
    logic op = 0;
    logic [31:0] address = '0;
    logic store_through = 0;
    logic out_valid;
    logic out_stall = 0;
    logic [1:0] command;
    logic [31:0] line_address;
    logic [1:0] way;
    logic hit;
    logic last;

    cache_scoreboard tracker;
    int cycle_count = 0;
    int accesses_sent = 0;
    int wait_left = 0;
    logic hold_active = 0;
    logic stall_random = 1;
    event hold_start;

    set_assoc_cache_controller dut (.*);

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Long receiver hold-off, counted here once requested.
    always
    begin
        @(hold_start);
        @(posedge clk);
        hold_active <= 1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active <= 0;
    end

    // Result side: after each taken transfer the receiver stalls for a random wait while stall_random is set.
    always @(posedge clk)
    begin
        cache_result_t r;
        int next_wait;
        next_wait = wait_left;
        if (rst_n && out_valid && !out_stall)
        begin
            r.command = command;
            r.line_address = line_address;
            r.way = way;
            r.hit = hit;
            r.last = last;
            tracker.check_result(r);
            next_wait = stall_random ? int'($urandom_range(0, 15)) : 0;
        end
        else if (next_wait > 0)
            next_wait = next_wait - 1;
        wait_left <= next_wait;
        out_stall <= hold_active || (next_wait != 0);
    end

    task automatic write_reg(input logic [sacc_pkg::PADDR_BITS-1:0] a, input logic [31:0] d);
        @(posedge clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= a;
        pwdata <= d;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        if (a == sacc_pkg::REG_POLICY)
            tracker.set_policy(d[1:0]);
        else if (a == sacc_pkg::REG_MULT)
            tracker.mult = d;
        else if (a == sacc_pkg::REG_INC)
            tracker.inc = d;
        else
            tracker.modulus = d;
    endtask

    // Offers one access, after a random gap when gaps is set, and holds it until it is taken.
    task automatic send_access(input logic is_write, input logic [31:0] a, input logic wt,
                               input logic gaps);
        int gap;
        gap = gaps ? int'($urandom_range(0, 15)) : 0;
        if (gap > 0)
        begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1;
        op <= is_write;
        address <= a;
        store_through <= wt;
        do
            @(posedge clk);
        while (in_stall);
        tracker.note_access(is_write, a, wt);
        accesses_sent++;
    endtask

    task automatic drain();
        in_valid <= 0;
        while (tracker.pending.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    // Address inside a small pool of tags so that sets fill and evict.
    function automatic logic [31:0] pick_address(int set_span, int tag_span);
        logic [31:0] a;
        a = $urandom;
        a[11:6] = 6'($urandom_range(0, set_span - 1));
        a[31:12] = 20'($urandom_range(0, tag_span - 1));
        if ($urandom_range(0, 9) == 0)
            a[31:12] = 20'($urandom);
        return a;
    endfunction

    task automatic random_phase(int count, int set_span, int tag_span);
        for (int i = 0; i < count; i++)
            send_access($urandom_range(0, 2) == 0, pick_address(set_span, tag_span),
                        $urandom_range(0, 3) == 0, $urandom_range(0, 3) != 0);
    endtask

    initial
    begin
        tracker = new();
        repeat (10) @(posedge clk);
        rst_n <= 1;
        repeat (sacc_pkg::NUM_SETS + 5) @(posedge clk);

        // Directed: fill one set, hit, dirty, evict a clean line, write paths, extremes.
        for (int t = 0; t < 4; t++)
            send_access(0, {20'(t), 6'd3, 6'd0}, 0, 0);
        send_access(0, {20'd2, 6'd3, 6'h3F}, 0, 0);
        send_access(1, {20'd1, 6'd3, 6'd5}, 0, 0);
        send_access(1, {20'd0, 6'd3, 6'd5}, 1, 0);
        send_access(1, {20'd9, 6'd3, 6'd5}, 0, 0);
        send_access(1, {20'd9, 6'd3, 6'd5}, 1, 0);
        send_access(0, {20'd5, 6'd3, 6'd0}, 0, 0);
        send_access(0, 32'hFFFF_FFFF, 0, 0);
        send_access(1, 32'hFFFF_FFFF, 0, 0);
        send_access(0, 32'h0000_0000, 0, 0);
        send_access(1, 32'h0000_0000, 1, 0);
        drain();

        write_reg(sacc_pkg::REG_POLICY, {30'd0, sacc_pkg::POL_MRU});
        for (int t = 10; t < 16; t++)
            send_access(t[0], {20'(t), 6'd7, 6'd0}, 0, 0);
        random_phase(40, 4, 8);
        drain();

        write_reg(sacc_pkg::REG_POLICY, {30'd0, sacc_pkg::POL_RAND});
        random_phase(40, 4, 8);
        drain();
        write_reg(sacc_pkg::REG_MULT, 32'hFFFF_FFFF);
        write_reg(sacc_pkg::REG_INC, 32'hFFFF_FFFF);
        write_reg(sacc_pkg::REG_MOD, 32'd0);
        random_phase(30, 4, 8);
        drain();
        write_reg(sacc_pkg::REG_MULT, 32'd0);
        write_reg(sacc_pkg::REG_INC, 32'd7);
        write_reg(sacc_pkg::REG_MOD, 32'd1);
        random_phase(15, 4, 8);
        drain();
        write_reg(sacc_pkg::REG_MULT, $urandom);
        write_reg(sacc_pkg::REG_INC, $urandom);
        write_reg(sacc_pkg::REG_MOD, 32'hFFFF_FFFF);
        random_phase(20, 8, 6);
        drain();

        // Long receiver hold-off while accesses keep coming.
        write_reg(sacc_pkg::REG_POLICY, 32'd3);
        -> hold_start;
        random_phase(20, 4, 8);
        drain();

        write_reg(sacc_pkg::REG_POLICY, {30'd0, sacc_pkg::POL_LRU});
        stall_random = 0;
        for (int i = 0; i < 25; i++)
            send_access($urandom_range(0, 1), pick_address(4, 6), $urandom_range(0, 1), 0);
        stall_random = 1;
        random_phase(60, 16, 6);
        drain();

        $display("Sent %0d accesses, checked %0d results under LRU, MRU and random",
                 accesses_sent, tracker.checked);
        $display("victim policies with several generator settings and a long output hold.");
        if (tracker.errors == 0 && tracker.pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
